// ===== hw/rtl/integer_to_ascii_radix_core_assert.svh =====
// assertion macros used by the rtl datapath file
// each macro expects clk and rst_n in the scope where it is used
`ifndef INTEGER_TO_ASCII_RADIX_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge outside reset
`define ITOA_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("itoa assertion failed: invariant violated");

// consequent holds in the same cycle as the antecedent
`define ITOA_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itoa assertion failed: implication violated");

`else

`define ITOA_ASSERT_ALWAYS(label, cond)
`define ITOA_ASSERT_IMPLIES(label, ante, cons)

`endif

`endif

// ===== hw/rtl/itoa_pkg.sv =====
package itoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 7;
    localparam int MAX_DIGITS = 32;
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    // quotient bits developed per divider cycle
    localparam int BITS_PER_BEAT = 8;
    localparam int BEATS         = VALUE_W / BITS_PER_BEAT;
    localparam int BEAT_W        = $clog2(BEATS);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
    localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd9;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    // register index on the configuration port
    localparam logic REG_RADIX = 1'b0;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic div_step;
        logic div_last;
        logic load_sign;
        logic load_digit;
    } itoa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic neg;
        logic quo_zero_next;
        logic last_digit;
        logic out_free;
    } itoa_status_t;

    // out-of-range radix values are pulled to the nearest legal base
    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        begin
            res = r;
            if (r < RADIX_MIN)
            begin
                res = RADIX_MIN;
            end
            else if (r > RADIX_MAX)
            begin
                res = RADIX_MAX;
            end
            return res;
        end
    endfunction

    // digit value to ascii, letters above nine
    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] res;
        begin
            if (d > DEC_DIGITS)
            begin
                res = CHAR_A + CHAR_W'(d - RADIX_DEC);
            end
            else
            begin
                res = CHAR_ZERO + CHAR_W'(d);
            end
            return res;
        end
    endfunction

endpackage

// ===== hw/rtl/itoa_ctrl.sv =====
module itoa_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  itoa_pkg::itoa_status_t status,
    output itoa_pkg::itoa_cmd_t   cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [itoa_pkg::BEAT_W-1:0]  beat_reg;
    logic [itoa_pkg::BEAT_W-1:0]  beat_next;
    logic                         beat_end;

    assign beat_end = (beat_reg == itoa_pkg::BEAT_W'(itoa_pkg::BEATS - 1));
    assign s_tready = (state_reg == ST_IDLE);

    // commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        beat_next  = beat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.start  = 1'b1;
                    beat_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_last = beat_end;
                beat_next    = beat_reg + 1'b1;
                if (beat_end && status.quo_zero_next)
                begin
                    state_next = status.neg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.load_sign = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_digit = 1'b1;
                    if (status.last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and beat counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            beat_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            beat_reg  <= beat_next;
        end
    end

endmodule

// ===== hw/rtl/itoa_dp.sv =====
`include "integer_to_ascii_radix_core_assert.svh"

module itoa_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [itoa_pkg::RADIX_W-1:0]        radix,
    input  logic [itoa_pkg::VALUE_W-1:0]        value,
    input  itoa_pkg::itoa_cmd_t                 cmd,
    output itoa_pkg::itoa_status_t              status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [itoa_pkg::CHAR_W-1:0]         out_char,
    output logic                                out_last
);

    logic [itoa_pkg::RADIX_W-1:0]  r_reg;
    logic [itoa_pkg::RADIX_W-1:0]  r_next;
    logic                          neg_reg;
    logic                          neg_next;
    logic [itoa_pkg::VALUE_W-1:0]  quo_reg;
    logic [itoa_pkg::VALUE_W-1:0]  quo_next;
    logic [itoa_pkg::RADIX_W-1:0]  rem_reg;
    logic [itoa_pkg::RADIX_W-1:0]  rem_next;
    logic [itoa_pkg::CNT_W-1:0]    cnt_reg;
    logic [itoa_pkg::CNT_W-1:0]    cnt_next;
    logic                          valid_reg;
    logic                          valid_next;
    logic [itoa_pkg::CHAR_W-1:0]   char_reg;
    logic [itoa_pkg::CHAR_W-1:0]   char_next;
    logic                          last_reg;
    logic                          last_next;

    logic [itoa_pkg::CHAR_W-1:0]   stack [itoa_pkg::MAX_DIGITS];

    logic [itoa_pkg::RADIX_W-1:0]  r_clamped;
    logic                          start_neg;
    logic [itoa_pkg::VALUE_W-1:0]  quo_w;
    logic [itoa_pkg::RADIX_W-1:0]  rem_w;
    logic [itoa_pkg::CNT_W-1:0]    cnt_dec;
    logic [itoa_pkg::IDX_W-1:0]    rd_idx;
    logic [itoa_pkg::IDX_W-1:0]    wr_idx;

    assign r_clamped = itoa_pkg::clamp_radix(radix);
    assign start_neg = (r_clamped == itoa_pkg::RADIX_DEC) && value[itoa_pkg::VALUE_W-1];
    assign cnt_dec   = cnt_reg - 1'b1;
    assign rd_idx    = cnt_dec[itoa_pkg::IDX_W-1:0];
    assign wr_idx    = cnt_reg[itoa_pkg::IDX_W-1:0];

    // restoring divider, one quotient byte per beat, msb first
    always_comb
    begin
        logic [itoa_pkg::RADIX_W:0] trial;
        quo_w = quo_reg;
        rem_w = rem_reg;
        for (int j = 0; j < itoa_pkg::BITS_PER_BEAT; j++)
        begin
            trial = {rem_w, quo_w[itoa_pkg::VALUE_W-1]};
            quo_w = {quo_w[itoa_pkg::VALUE_W-2:0], 1'b0};
            if (trial >= {1'b0, r_reg})
            begin
                rem_w    = itoa_pkg::RADIX_W'(trial - {1'b0, r_reg});
                quo_w[0] = 1'b1;
            end
            else
            begin
                rem_w = trial[itoa_pkg::RADIX_W-1:0];
            end
        end
    end

    // operand, digit count and output word updates
    always_comb
    begin
        r_next     = r_reg;
        neg_next   = neg_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg & ~out_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        if (cmd.start)
        begin
            r_next   = r_clamped;
            neg_next = start_neg;
            quo_next = start_neg ? (~value + 1'b1) : value;
            rem_next = '0;
            cnt_next = '0;
        end
        if (cmd.div_step)
        begin
            quo_next = quo_w;
            rem_next = cmd.div_last ? '0 : rem_w;
            if (cmd.div_last)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (cmd.load_sign)
        begin
            valid_next = 1'b1;
            char_next  = itoa_pkg::CHAR_MINUS;
            last_next  = 1'b0;
        end
        if (cmd.load_digit)
        begin
            valid_next = 1'b1;
            char_next  = stack[rd_idx];
            last_next  = (cnt_dec == '0);
            cnt_next   = cnt_dec;
        end
    end

    // control and operand registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg     <= itoa_pkg::RADIX_RESET;
            neg_reg   <= 1'b0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            r_reg     <= r_next;
            neg_reg   <= neg_next;
            quo_reg   <= quo_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // digit stack, least significant digit pushed first
    always_ff @(posedge clk)
    begin
        if (cmd.div_step && cmd.div_last)
        begin
            stack[wr_idx] <= itoa_pkg::digit_char(rem_w);
        end
    end

    assign status.neg           = neg_reg;
    assign status.quo_zero_next = (quo_w == '0);
    assign status.last_digit    = (cnt_reg == itoa_pkg::CNT_W'(1));
    assign status.out_free      = ~valid_reg | out_ready;

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

    `ITOA_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= itoa_pkg::CNT_W'(itoa_pkg::MAX_DIGITS))
    `ITOA_ASSERT_ALWAYS(a_rem_below_radix, rem_reg < r_reg)
    `ITOA_ASSERT_IMPLIES(a_pop_nonempty, cmd.load_digit, cnt_reg != '0)
    `ITOA_ASSERT_IMPLIES(a_no_overwrite, valid_reg && !out_ready, !(cmd.load_sign || cmd.load_digit))

endmodule

// ===== hw/rtl/integer_to_ascii_radix_core.sv =====
// integer to text converter: each 32-bit word on the input stream becomes its
// ascii text in the base held in the radix register (address 0, reset 10,
// values below 2 act as 2 and above 36 as 36), one character per output word,
// most significant first, tlast on the final character; digits above nine are
// lower-case letters, radix 10 prints negative values with a leading minus and
// every other base reads the word as unsigned. the digits come from one shared
// restoring divider that develops eight quotient bits a cycle; the word is
// loaded, its digits are developed one after another, least significant
// first, then the characters leave one per cycle, the minus sign first,
// while the output is not stalled. one item is converted at a time; the next
// word is taken as soon as the last character sits in the output register.
module integer_to_ascii_radix_core
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] character, [7] zero
    output logic        m_tlast
);

    logic [itoa_pkg::RADIX_W-1:0] radix_reg;
    logic [itoa_pkg::RADIX_W-1:0] radix_next;
    logic                         reg_sel;
    logic                         wr_en;
    itoa_pkg::itoa_cmd_t          cmd;
    itoa_pkg::itoa_status_t       status;
    logic [itoa_pkg::CHAR_W-1:0]  out_char;

    // register write decode
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == itoa_pkg::REG_RADIX);
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb
    begin
        radix_next = radix_reg;
        if (wr_en && reg_sel)
        begin
            radix_next = pwdata[itoa_pkg::RADIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= itoa_pkg::RADIX_RESET;
        end
        else
        begin
            radix_reg <= radix_next;
        end
    end

    // register read
    assign prdata = reg_sel ? {{(32 - itoa_pkg::RADIX_W){1'b0}}, radix_reg} : 32'd0;

    itoa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    itoa_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .radix     (radix_reg),
        .value     (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_char  (out_char),
        .out_last  (m_tlast)
    );

    assign m_tdata = {1'b0, out_char};

endmodule
